@@ hdl/clkpr_pkg.sv @@
package clkpr_pkg;

    // Store and field geometry
    localparam int PAGE_COUNT  = 4096;
    localparam int FRAME_COUNT = 64;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int FCNT_W      = 7;
    localparam int PS_W        = 17;
    localparam int VA_W        = 32;
    localparam int OFS_W       = 16;
    localparam int PA_W        = 22;
    localparam int CNT_W       = 32;
    localparam int DIV_CNT_W   = $clog2(VA_W);
    localparam int MAP_W       = FRAME_W + 1;

    localparam logic [PS_W-1:0]   PS_MAX   = PS_W'(65536);
    localparam logic [FCNT_W-1:0] FC_MAX   = FCNT_W'(FRAME_COUNT);
    localparam logic [CNT_W-1:0]  CNT_FULL = '1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_COUNT = 1'b0,
        CFG_PAGE_SIZE   = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_LOOK,
        ST_SWEEP,
        ST_OWN,
        ST_VIC,
        ST_UPD,
        ST_MUL,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic count_ref;
        logic res_err;
        logic map_rd;
        logic hit_set;
        logic count_fault;
        logic take_free;
        logic wrap_hand;
        logic sweep_step;
        logic pick_victim;
        logic vic_rd;
        logic vic_inv;
        logic install;
        logic mul;
        logic res_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic range_err;
        logic map_hit;
        logic free_avail;
        logic bit_at_hand;
        logic out_busy;
    } t_sts;

endpackage

@@ hdl/clock_page_replacement_unit.sv @@
// Clock (second-chance) page replacement. Each input item is a virtual address;
// it is split into page and offset by the configured page size, translated
// through a 4096-entry page table onto up to 64 frames, and one result item
// comes back with hit/fault, frame, physical address and saturating reference
// and fault totals. Pages at or beyond 4096 give range_error and change nothing.
// After reset the page table is swept invalid, entry by entry, during which no
// item is taken (configuration writes still are). One item at a time: the
// bit-serial divider sets most of the latency, and an eviction also waits while
// the clock hand clears each set reference bit it passes (at most the frame
// count). A new item is taken while the previous result still waits at the
// output.
module clock_page_replacement_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [clkpr_pkg::VA_W-1:0]    i_virtual_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [clkpr_pkg::VA_W-1:0]    o_page_index,
    output logic [clkpr_pkg::OFS_W-1:0]   o_page_offset,
    output logic                          o_was_hit,
    output logic [clkpr_pkg::FRAME_W-1:0] o_frame_index,
    output logic [clkpr_pkg::PA_W-1:0]    o_physical_address,
    output logic [clkpr_pkg::CNT_W-1:0]   o_reference_total,
    output logic [clkpr_pkg::CNT_W-1:0]   o_fault_total,
    output logic                          o_range_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [clkpr_pkg::PS_W-1:0]    i_cfg_data
);
    import clkpr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    clkpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    clkpr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_virtual_address  (i_virtual_address),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_page_index       (o_page_index),
        .o_page_offset      (o_page_offset),
        .o_was_hit          (o_was_hit),
        .o_frame_index      (o_frame_index),
        .o_physical_address (o_physical_address),
        .o_reference_total  (o_reference_total),
        .o_fault_total      (o_fault_total),
        .o_range_error      (o_range_error)
    );

endmodule

@@ hdl/clkpr_div.sv @@
module clkpr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [clkpr_pkg::VA_W-1:0]  i_dividend,
    input  logic [clkpr_pkg::PS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [clkpr_pkg::VA_W-1:0]  o_quotient,
    output logic [clkpr_pkg::PS_W-1:0]  o_remainder
);
    import clkpr_pkg::*;

    logic [VA_W-1:0]      r_quo;
    logic [PS_W-1:0]      r_rem;
    logic [PS_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PS_W:0]        trial;
    logic                 ge;

    // One quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[VA_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(VA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VA_W-2:0], ge};
            r_rem <= ge ? PS_W'(trial - {1'b0, r_dvs}) : trial[PS_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ hdl/clkpr_dp.sv @@
module clkpr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clkpr_pkg::t_cmd               i_cmd,
    output clkpr_pkg::t_sts               o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [clkpr_pkg::PS_W-1:0]    i_cfg_data,
    input  logic [clkpr_pkg::VA_W-1:0]    i_virtual_address,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [clkpr_pkg::VA_W-1:0]    o_page_index,
    output logic [clkpr_pkg::OFS_W-1:0]   o_page_offset,
    output logic                          o_was_hit,
    output logic [clkpr_pkg::FRAME_W-1:0] o_frame_index,
    output logic [clkpr_pkg::PA_W-1:0]    o_physical_address,
    output logic [clkpr_pkg::CNT_W-1:0]   o_reference_total,
    output logic [clkpr_pkg::CNT_W-1:0]   o_fault_total,
    output logic                          o_range_error
);
    import clkpr_pkg::*;

    // Configuration and clock state
    logic [FCNT_W-1:0]      r_fc;
    logic [PS_W-1:0]        r_ps;
    logic [FCNT_W-1:0]      eff_n;
    logic [PS_W-1:0]        eff_ps;
    logic [FRAME_COUNT-1:0] r_bits;
    logic [FRAME_W-1:0]     r_hand;
    logic [FRAME_W-1:0]     hand_next;
    logic [FCNT_W-1:0]      r_taken;
    logic [CNT_W-1:0]       r_ref;
    logic [CNT_W-1:0]       r_flt;
    logic [PAGE_W-1:0]      r_clr;

    // Per-item working registers
    logic [FRAME_W-1:0]     r_frame;
    logic                   r_hit;
    logic                   r_err;
    logic [PA_W-1:0]        r_phys;

    // Divider
    logic                   div_done;
    logic [VA_W-1:0]        quo;
    logic [PS_W-1:0]        rem;
    logic [PAGE_W-1:0]      page;

    // Memories
    logic [MAP_W-1:0]       r_map_mem [PAGE_COUNT];
    logic [MAP_W-1:0]       r_map_q;
    logic [PAGE_W-1:0]      map_addr;
    logic [MAP_W-1:0]       map_wdata;
    logic                   map_we;
    logic [PAGE_W-1:0]      r_own_mem [FRAME_COUNT];
    logic [PAGE_W-1:0]      r_own_q;
    logic [FRAME_W-1:0]     own_addr;

    // Output register
    logic                   r_out_valid;
    logic [VA_W-1:0]        r_o_page;
    logic [OFS_W-1:0]       r_o_ofs;
    logic                   r_o_hit;
    logic [FRAME_W-1:0]     r_o_frame;
    logic [PA_W-1:0]        r_o_phys;
    logic [CNT_W-1:0]       r_o_ref;
    logic [CNT_W-1:0]       r_o_flt;
    logic                   r_o_err;

    // Clamp the configured values
    always_comb begin
        if (r_fc == '0) begin
            eff_n = FCNT_W'(1);
        end else if (r_fc > FC_MAX) begin
            eff_n = FC_MAX;
        end else begin
            eff_n = r_fc;
        end
        if (r_ps == '0) begin
            eff_ps = PS_W'(1);
        end else if (r_ps > PS_MAX) begin
            eff_ps = PS_MAX;
        end else begin
            eff_ps = r_ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= FC_MAX;
            r_ps <= PS_W'(4096);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_COUNT: r_fc <= i_cfg_data[FCNT_W-1:0];
                CFG_PAGE_SIZE:   r_ps <= i_cfg_data;
                default:         r_ps <= r_ps;
            endcase
        end
    end

    clkpr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.load),
        .i_dividend  (i_virtual_address),
        .i_divisor   (eff_ps),
        .o_done      (div_done),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    assign page = quo[PAGE_W-1:0];

    // Advance the hand, wrapping at the frame count
    assign hand_next = ({1'b0, r_hand} + 1'b1 >= eff_n) ? '0 : FRAME_W'(r_hand + 1'b1);

    // Page table port: clear, look up, invalidate victim, install
    always_comb begin
        map_we    = 1'b0;
        map_addr  = page;
        map_wdata = '0;
        priority if (i_cmd.clr_step) begin
            map_we   = 1'b1;
            map_addr = r_clr;
        end else if (i_cmd.vic_rd) begin
            map_addr = r_own_q;
        end else if (i_cmd.vic_inv) begin
            map_addr = r_own_q;
            map_we   = r_map_q[MAP_W-1] && (r_map_q[FRAME_W-1:0] == r_frame);
        end else if (i_cmd.install) begin
            map_we    = 1'b1;
            map_wdata = {1'b1, r_frame};
        end else if (i_cmd.map_rd) begin
            map_addr = page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_addr] <= map_wdata;
        end
        r_map_q <= r_map_mem[map_addr];
    end

    // Frame owner store; hold the victim's owner until it is invalidated
    assign own_addr = i_cmd.install ? r_frame : r_hand;

    always_ff @(posedge i_clk) begin
        if (i_cmd.install) begin
            r_own_mem[own_addr] <= page;
        end
        if (i_cmd.pick_victim) begin
            r_own_q <= r_own_mem[own_addr];
        end
    end

    // Clock state, counters and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_hand  <= '0;
            r_taken <= '0;
            r_ref   <= '0;
            r_flt   <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.count_ref && r_ref != CNT_FULL) begin
                r_ref <= r_ref + 1'b1;
            end
            if (i_cmd.count_fault && r_flt != CNT_FULL) begin
                r_flt <= r_flt + 1'b1;
            end
            if (i_cmd.hit_set) begin
                r_bits[r_map_q[FRAME_W-1:0]] <= 1'b1;
            end
            if (i_cmd.take_free) begin
                r_taken <= r_taken + 1'b1;
            end
            if (i_cmd.wrap_hand && {1'b0, r_hand} >= eff_n) begin
                r_hand <= '0;
            end
            if (i_cmd.sweep_step) begin
                r_bits[r_hand] <= 1'b0;
                r_hand         <= hand_next;
            end
            if (i_cmd.pick_victim) begin
                r_hand <= hand_next;
            end
            if (i_cmd.install) begin
                r_bits[r_frame] <= 1'b1;
            end
        end
    end

    // Per-item result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit <= 1'b0;
            r_err <= 1'b0;
        end
        if (i_cmd.res_err) begin
            r_err   <= 1'b1;
            r_frame <= '0;
            r_phys  <= '0;
        end
        if (i_cmd.hit_set) begin
            r_hit   <= 1'b1;
            r_frame <= r_map_q[FRAME_W-1:0];
        end
        if (i_cmd.take_free) begin
            r_frame <= r_taken[FRAME_W-1:0];
        end
        if (i_cmd.pick_victim) begin
            r_frame <= r_hand;
        end
        if (i_cmd.mul) begin
            r_phys <= PA_W'(r_frame) * PA_W'(eff_ps) + PA_W'(rem);
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_o_page  <= quo;
            r_o_ofs   <= rem[OFS_W-1:0];
            r_o_hit   <= r_hit;
            r_o_frame <= r_frame;
            r_o_phys  <= r_phys;
            r_o_ref   <= r_ref;
            r_o_flt   <= r_flt;
            r_o_err   <= r_err;
        end
    end

    assign o_sts.clr_last    = (r_clr == '1);
    assign o_sts.div_done    = div_done;
    assign o_sts.range_err   = (quo[VA_W-1:PAGE_W] != '0);
    assign o_sts.map_hit     = r_map_q[MAP_W-1];
    assign o_sts.free_avail  = (r_taken < eff_n);
    assign o_sts.bit_at_hand = r_bits[r_hand];
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_page_index       = r_o_page;
    assign o_page_offset      = r_o_ofs;
    assign o_was_hit          = r_o_hit;
    assign o_frame_index      = r_o_frame;
    assign o_physical_address = r_o_phys;
    assign o_reference_total  = r_o_ref;
    assign o_fault_total      = r_o_flt;
    assign o_range_error      = r_o_err;

endmodule

@@ hdl/clkpr_ctrl.sv @@
module clkpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  clkpr_pkg::t_sts i_sts,
    output clkpr_pkg::t_cmd o_cmd
);
    import clkpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            // Sweep the page table invalid after reset
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_CHECK;
                end
            end
            // Drop out-of-range pages, else look the page up
            ST_CHECK: begin
                if (i_sts.range_err) begin
                    o_cmd.res_err = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.count_ref = 1'b1;
                    o_cmd.map_rd    = 1'b1;
                    n_state         = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (i_sts.map_hit) begin
                    o_cmd.hit_set = 1'b1;
                    n_state       = ST_MUL;
                end else begin
                    o_cmd.count_fault = 1'b1;
                    if (i_sts.free_avail) begin
                        o_cmd.take_free = 1'b1;
                        n_state         = ST_UPD;
                    end else begin
                        o_cmd.wrap_hand = 1'b1;
                        n_state         = ST_SWEEP;
                    end
                end
            end
            // Clear set bits until a clear one turns up
            ST_SWEEP: begin
                if (i_sts.bit_at_hand) begin
                    o_cmd.sweep_step = 1'b1;
                end else begin
                    o_cmd.pick_victim = 1'b1;
                    n_state           = ST_OWN;
                end
            end
            ST_OWN: begin
                o_cmd.vic_rd = 1'b1;
                n_state      = ST_VIC;
            end
            ST_VIC: begin
                o_cmd.vic_inv = 1'b1;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.install = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/clkpr_chk.sv @@
module clkpr_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [clkpr_pkg::VA_W-1:0]    i_virtual_address,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [clkpr_pkg::VA_W-1:0]    o_page_index,
    input logic [clkpr_pkg::OFS_W-1:0]   o_page_offset,
    input logic                          o_was_hit,
    input logic [clkpr_pkg::FRAME_W-1:0] o_frame_index,
    input logic [clkpr_pkg::PA_W-1:0]    o_physical_address,
    input logic [clkpr_pkg::CNT_W-1:0]   o_reference_total,
    input logic [clkpr_pkg::CNT_W-1:0]   o_fault_total,
    input logic                          o_range_error,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic                          i_cfg_index,
    input logic [clkpr_pkg::PS_W-1:0]    i_cfg_data
);
    import clkpr_pkg::*;

    // A waiting result item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_page_index)
            && $stable(o_fault_total))
        else $error("result item changed before it was taken");

    // Faults never outnumber references
    a_fault_le_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fault_total <= o_reference_total)
        else $error("fault total above reference total");

    // Rejected items carry no translation
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_was_hit && o_frame_index == '0
            && o_physical_address == '0)
        else $error("range error with a translation");

    // Accepted pages lie inside the table
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_range_error |-> o_page_index[VA_W-1:PAGE_W] == '0)
        else $error("page beyond table without range error");

endmodule

bind clock_page_replacement_unit clkpr_chk u_chk (.*);
